### rtl/core/buddy_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// shared property wrappers for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// clocked check, masked while reset is applied
`define BBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check that also holds across reset
`define BBA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    // default sizing
    localparam int MAX_LEVELS_DEF       = 10;
    localparam int BLOCK_BYTES_LOG2_DEF = 12;

    // field widths fixed by the interface
    localparam int LEVEL_W  = 4;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 64;
    localparam int PADDR_W  = 4;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // register select (paddr bit 3)
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_TOP  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_ALIGN = 3'd1,
        ST_DFREE = 3'd2,
        ST_RANGE = 3'd3,
        ST_LEVEL = 3'd4,
        ST_NOMEM = 3'd5
    } t_status;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_CINI,
        S_ACHK,
        S_ASRCH,
        S_APOP,
        S_APN,
        S_ASPL,
        S_PUSH,
        S_OKFIN,
        S_FSUB,
        S_FCHK,
        S_FFB,
        S_FLOOP,
        S_FBUD,
        S_FULP,
        S_FULN,
        S_FULB,
        S_FMUP,
        S_FMLO,
        S_MRD,
        S_MWR
    } t_state;

endpackage

### rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// binary buddy allocator with per-level doubly linked free lists
// ----------------------------------------------------------------------------
// An allocate or free is taken when start is high and busy is low; one result
// follows on o_valid for exactly one cycle and cannot be held off. Block and
// list-link bookkeeping lives in one block store (one read, one write per
// cycle) and the list heads in registers, driven by a small sequencer, so the
// store access count sets the latency. An allocate searches upward past empty
// lists, pops the first block found, relinks its successor when it has one and
// splits down to the asked level; a free checks the address, marks the block
// free, merges it with each free buddy and pushes it onto its final list,
// relinking the old head when that list is not empty. A failed check ends the
// command sooner. After reset and after every top_level write the store is
// swept with busy high; configuration writes are still taken during the sweep.
`include "buddy_block_allocator_defines.svh"

module buddy_block_allocator #(
    parameter int MAX_LEVELS       = bba_pkg::MAX_LEVELS_DEF,
    parameter int BLOCK_BYTES_LOG2 = bba_pkg::BLOCK_BYTES_LOG2_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [bba_pkg::LEVEL_W-1:0]   i_level,
    input  logic [bba_pkg::ADDR_W-1:0]    i_address,
    // result channel
    output logic                          o_valid,
    output logic [bba_pkg::STATUS_W-1:0]  o_status,
    output logic [bba_pkg::ADDR_W-1:0]    o_result_address,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]   paddr,
    input  logic [bba_pkg::ADDR_W-1:0]    pwdata,
    output logic [bba_pkg::ADDR_W-1:0]    prdata,
    output logic                          pready
);
    import bba_pkg::*;

    localparam int AW    = MAX_LEVELS;
    localparam int DEPTH = 1 << AW;
    localparam int NL    = MAX_LEVELS + 1;
    localparam int HW    = $clog2(NL);
    localparam int IW    = ADDR_W - BLOCK_BYTES_LOG2;
    localparam int TOP_RST_I = (MAX_LEVELS < 10) ? MAX_LEVELS : 10;
    localparam logic [LEVEL_W-1:0] TOP_RST = LEVEL_W'(TOP_RST_I);
    localparam logic [AW:0] NIL = {1'b1, {AW{1'b0}}};

    // one entry of the block store
    typedef struct packed {
        logic               free;
        logic [LEVEL_W-1:0] order;
        logic [AW:0]        nxt;
        logic [AW:0]        prv;
    } t_word;

    // field update applied by the read-modify-write step
    typedef struct packed {
        logic               set_free;
        logic               free;
        logic               set_order;
        logic [LEVEL_W-1:0] order;
        logic               set_nxt;
        logic [AW:0]        nxt;
        logic               set_prv;
        logic [AW:0]        prv;
    } t_mod;

    function automatic t_mod f_mod(logic sf, logic f, logic so, logic [LEVEL_W-1:0] o,
                                   logic sn, logic [AW:0] n, logic sp, logic [AW:0] p);
        t_mod m;
        m = '{set_free: sf, free: f, set_order: so, order: o,
              set_nxt: sn, nxt: n, set_prv: sp, prv: p};
        return m;
    endfunction

    function automatic t_word f_apply(t_word w, t_mod m);
        t_word r;
        r = w;
        if (m.set_free)  r.free  = m.free;
        if (m.set_order) r.order = m.order;
        if (m.set_nxt)   r.nxt   = m.nxt;
        if (m.set_prv)   r.prv   = m.prv;
        return r;
    endfunction

    // registers
    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic               r_op, n_op;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [LEVEL_W-1:0] r_ord, n_ord;
    logic [LEVEL_W-1:0] r_plev, n_plev;
    logic [AW-1:0]      r_c, n_c;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_bud, n_bud;
    logic [AW-1:0]      r_t, n_t;
    logic [AW-1:0]      r_ma, n_ma;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [AW:0]        r_n, n_n;
    logic [AW:0]        r_p, n_p;
    logic [AW:0]        r_nprev, n_nprev;
    t_mod               r_mod, n_mod;
    logic [ADDR_W-1:0]  r_off, n_off;
    logic               r_lt, n_lt;
    logic               r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]  r_res, n_res;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [LEVEL_W-1:0] r_top, n_top;

    // block store and list heads
    t_word              mem [DEPTH];
    t_word              r_rdata;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    t_word              mem_wd;
    logic [AW-1:0]      mem_ra;
    logic [AW:0]        r_heads [NL];
    logic [HW-1:0]      w_hsel;
    logic [AW:0]        w_head;
    logic               heads_we;
    logic [AW:0]        heads_wd;

    // register port decode
    logic               w_cfg_we;
    logic               w_top_we;
    logic [LEVEL_W-1:0] w_top_new;
    logic [LEVEL_W-1:0] w_top_init;
    logic               w_accept;
    logic [ADDR_W:0]    w_diff;
    logic [AW-1:0]      w_fidx;
    logic [AW-1:0]      w_lower;
    logic [AW-1:0]      w_upper;

    assign pready    = 1'b1;
    assign w_cfg_we  = psel && penable && pwrite;
    assign w_top_we  = w_cfg_we && (paddr[3] == REG_TOP);
    assign w_top_new = (32'(pwdata[LEVEL_W-1:0]) > MAX_LEVELS) ? LEVEL_W'(MAX_LEVELS)
                                                               : pwdata[LEVEL_W-1:0];
    assign w_top_init = !i_rst_n ? TOP_RST : w_top_new;
    assign prdata    = (paddr[3] == REG_TOP) ? ADDR_W'(r_top) : r_base;

    assign busy             = (r_state != S_IDLE);
    assign w_accept         = start && !busy;
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_result_address = r_res;

    // list head select, one place per cycle
    assign w_hsel = (r_state == S_PUSH) ? HW'(r_plev) : HW'(r_ord);
    assign w_head = r_heads[w_hsel];

    // free request helpers
    assign w_diff  = {1'b0, r_addr} - {1'b0, r_base};
    assign w_fidx  = r_off[BLOCK_BYTES_LOG2 +: AW];
    assign w_lower = (r_bud < r_idx) ? r_bud : r_idx;
    assign w_upper = (r_bud < r_idx) ? r_idx : r_bud;

    // sequencer next state and datapath
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_op     = r_op;
        n_level  = r_level;
        n_addr   = r_addr;
        n_ord    = r_ord;
        n_plev   = r_plev;
        n_c      = r_c;
        n_idx    = r_idx;
        n_bud    = r_bud;
        n_t      = r_t;
        n_ma     = r_ma;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_p      = r_p;
        n_nprev  = r_nprev;
        n_mod    = r_mod;
        n_off    = r_off;
        n_lt     = r_lt;
        n_valid  = 1'b0;
        n_status = r_status;
        n_res    = r_res;
        n_base   = r_base;
        n_top    = r_top;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '0;
        mem_ra   = '0;
        heads_we = 1'b0;
        heads_wd = '0;

        unique case (r_state)
            // sweep the store after reset or a top level change
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
                mem_wd = '{free: 1'b0, order: '0, nxt: NIL, prv: NIL};
                n_cnt  = r_cnt + AW'(1);
                if (&r_cnt) n_state = S_CINI;
            end
            S_CINI: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = '{free: 1'b1, order: r_top, nxt: NIL, prv: NIL};
                n_state = S_IDLE;
            end
            // take a command transfer
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_operation;
                    n_level = i_level;
                    n_addr  = i_address;
                    n_state = (i_operation == OP_FREE) ? S_FSUB : S_ACHK;
                end
            end
            // allocate
            S_ACHK: begin
                if (r_level > r_top) begin
                    n_valid  = 1'b1;
                    n_status = ST_LEVEL;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_ord   = r_level;
                    n_state = S_ASRCH;
                end
            end
            S_ASRCH: begin
                if (!w_head[AW]) begin
                    n_c     = w_head[AW-1:0];
                    mem_ra  = w_head[AW-1:0];
                    n_state = S_APOP;
                end else if (r_ord == r_top) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOMEM;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_ord = r_ord + LEVEL_W'(1);
                end
            end
            S_APOP: begin
                mem_we   = 1'b1;
                mem_wa   = r_c;
                mem_wd   = r_rdata;
                mem_wd.nxt = NIL;
                mem_wd.prv = NIL;
                heads_we = 1'b1;
                heads_wd = r_rdata.nxt;
                n_n      = r_rdata.nxt;
                n_state  = S_APN;
            end
            S_APN: begin
                if (!r_n[AW]) begin
                    n_ma    = r_n[AW-1:0];
                    n_mod   = f_mod(1'b0, 1'b0, 1'b0, '0, 1'b0, NIL, 1'b1, NIL);
                    n_ret   = S_ASPL;
                    n_state = S_MRD;
                end else begin
                    n_state = S_ASPL;
                end
            end
            // split down, upper half to the next lower list
            S_ASPL: begin
                if (r_ord > r_level) begin
                    n_t     = r_c + (AW'(1) << (r_ord - LEVEL_W'(1)));
                    n_plev  = r_ord - LEVEL_W'(1);
                    n_ord   = r_ord - LEVEL_W'(1);
                    n_state = S_PUSH;
                end else begin
                    n_ma    = r_c;
                    n_mod   = f_mod(1'b1, 1'b0, 1'b1, r_level, 1'b0, NIL, 1'b0, NIL);
                    n_ret   = S_OKFIN;
                    n_state = S_MRD;
                end
            end
            // push r_t onto list r_plev
            S_PUSH: begin
                mem_we   = 1'b1;
                mem_wa   = r_t;
                mem_wd   = '{free: 1'b1, order: r_plev, nxt: w_head, prv: NIL};
                heads_we = 1'b1;
                heads_wd = {1'b0, r_t};
                if (!w_head[AW]) begin
                    n_ma    = w_head[AW-1:0];
                    n_mod   = f_mod(1'b0, 1'b0, 1'b0, '0, 1'b0, NIL, 1'b1, {1'b0, r_t});
                    n_ret   = (r_op == OP_FREE) ? S_OKFIN : S_ASPL;
                    n_state = S_MRD;
                end else begin
                    n_state = (r_op == OP_FREE) ? S_OKFIN : S_ASPL;
                end
            end
            S_OKFIN: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_res    = (r_op == OP_FREE) ? '0
                         : r_base + (ADDR_W'(r_c) << BLOCK_BYTES_LOG2);
                n_state  = S_IDLE;
            end
            // free: offset from base
            S_FSUB: begin
                n_off   = w_diff[ADDR_W-1:0];
                n_lt    = w_diff[ADDR_W];
                n_state = S_FCHK;
            end
            S_FCHK: begin
                n_idx = w_fidx;
                if (r_lt || (r_off[BLOCK_BYTES_LOG2-1:0] != '0)) begin
                    n_valid  = 1'b1;
                    n_status = ST_ALIGN;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else if (r_level > r_top) begin
                    n_valid  = 1'b1;
                    n_status = ST_LEVEL;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else if ((r_off[ADDR_W-1:BLOCK_BYTES_LOG2] & ({IW{1'b1}} << r_top)) != '0)
                begin
                    n_valid  = 1'b1;
                    n_status = ST_RANGE;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else if ((w_fidx & ~({AW{1'b1}} << r_level)) != '0) begin
                    n_valid  = 1'b1;
                    n_status = ST_ALIGN;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else begin
                    mem_ra  = w_fidx;
                    n_state = S_FFB;
                end
            end
            S_FFB: begin
                if (r_rdata.free) begin
                    n_valid  = 1'b1;
                    n_status = ST_DFREE;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else begin
                    mem_we  = 1'b1;
                    mem_wa  = r_idx;
                    mem_wd  = '{free: 1'b1, order: r_level, nxt: NIL, prv: NIL};
                    n_ord   = r_level;
                    n_state = S_FLOOP;
                end
            end
            // merge loop, one buddy per pass
            S_FLOOP: begin
                if (r_ord < r_top) begin
                    n_bud   = r_idx ^ (AW'(1) << r_ord);
                    mem_ra  = r_idx ^ (AW'(1) << r_ord);
                    n_state = S_FBUD;
                end else begin
                    n_t     = r_idx;
                    n_plev  = r_ord;
                    n_state = S_PUSH;
                end
            end
            S_FBUD: begin
                if (!r_rdata.free || (r_rdata.order != r_ord)) begin
                    n_t     = r_idx;
                    n_plev  = r_ord;
                    n_state = S_PUSH;
                end else begin
                    if (w_head == {1'b0, r_bud}) begin
                        heads_we = 1'b1;
                        heads_wd = r_rdata.nxt;
                        n_p      = NIL;
                        n_nprev  = NIL;
                    end else begin
                        n_p      = r_rdata.prv;
                        n_nprev  = r_rdata.prv;
                    end
                    n_n     = r_rdata.nxt;
                    n_state = S_FULP;
                end
            end
            S_FULP: begin
                if (!r_p[AW]) begin
                    n_ma    = r_p[AW-1:0];
                    n_mod   = f_mod(1'b0, 1'b0, 1'b0, '0, 1'b1, r_n, 1'b0, NIL);
                    n_ret   = S_FULN;
                    n_state = S_MRD;
                end else begin
                    n_state = S_FULN;
                end
            end
            S_FULN: begin
                if (!r_n[AW]) begin
                    n_ma    = r_n[AW-1:0];
                    n_mod   = f_mod(1'b0, 1'b0, 1'b0, '0, 1'b0, NIL, 1'b1, r_nprev);
                    n_ret   = S_FULB;
                    n_state = S_MRD;
                end else begin
                    n_state = S_FULB;
                end
            end
            S_FULB: begin
                n_ma    = r_bud;
                n_mod   = f_mod(1'b0, 1'b0, 1'b0, '0, 1'b1, NIL, 1'b1, NIL);
                n_ret   = S_FMUP;
                n_state = S_MRD;
            end
            S_FMUP: begin
                n_idx   = w_lower;
                n_ma    = w_upper;
                n_mod   = f_mod(1'b1, 1'b0, 1'b0, '0, 1'b0, NIL, 1'b0, NIL);
                n_ret   = S_FMLO;
                n_state = S_MRD;
            end
            S_FMLO: begin
                n_ord   = r_ord + LEVEL_W'(1);
                n_ma    = r_idx;
                n_mod   = f_mod(1'b1, 1'b1, 1'b1, r_ord + LEVEL_W'(1), 1'b0, NIL, 1'b0, NIL);
                n_ret   = S_FLOOP;
                n_state = S_MRD;
            end
            // shared read-modify-write of one store entry
            S_MRD: begin
                mem_ra  = r_ma;
                n_state = S_MWR;
            end
            S_MWR: begin
                mem_we  = 1'b1;
                mem_wa  = r_ma;
                mem_wd  = f_apply(r_rdata, r_mod);
                n_state = r_ret;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register port transfer
        if (w_cfg_we) begin
            if (paddr[3] == REG_BASE) begin
                n_base = pwdata;
            end else begin
                n_top   = w_top_new;
                n_cnt   = '0;
                n_state = S_CLR;
            end
        end
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_base  <= '0;
            r_top   <= TOP_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            r_base  <= n_base;
            r_top   <= n_top;
        end
        r_ret    <= n_ret;
        r_op     <= n_op;
        r_level  <= n_level;
        r_addr   <= n_addr;
        r_ord    <= n_ord;
        r_plev   <= n_plev;
        r_c      <= n_c;
        r_idx    <= n_idx;
        r_bud    <= n_bud;
        r_t      <= n_t;
        r_ma     <= n_ma;
        r_n      <= n_n;
        r_p      <= n_p;
        r_nprev  <= n_nprev;
        r_mod    <= n_mod;
        r_off    <= n_off;
        r_lt     <= n_lt;
        r_status <= n_status;
        r_res    <= n_res;
    end

    // block store, write-first on a same-address read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= (mem_we && (mem_wa == mem_ra)) ? mem_wd : mem[mem_ra];
    end

    // list heads, one free block at the top level after init
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_top_we) begin
            for (int k = 0; k < NL; k++) begin
                r_heads[k] <= (k == int'(w_top_init)) ? {(AW+1){1'b0}} : NIL;
            end
        end else if (heads_we) begin
            r_heads[w_hsel] <= heads_wd;
        end
    end

    // checks
    `BBA_ASSERT(a_single_strobe, o_valid |=> !o_valid, "result strobe held for two cycles")
    `BBA_ASSERT(a_busy_after_start, start && !busy |=> busy, "busy not raised after command")
    `BBA_ASSERT(a_fail_zero_addr, o_valid && (o_status != ST_OK) |-> o_result_address == '0, "failed result carries an address")
    `BBA_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid, "result strobe after reset")

endmodule
